FILE: design/mklm_pkg.sv
// mklm_pkg: shared constants, register codes and types of the keyword line matcher.
// Used by mklm_cfg, mklm_cell and multi_keyword_line_match.
`default_nettype none
package mklm_pkg;

  localparam int NumKeywords     = 4;
  localparam int MaxKeywordBytes = 8;
  localparam int ByteW           = 8;
  localparam int KwTextW         = 64;
  localparam int KwLenW          = 4;
  localparam int KwCountW        = 3;
  localparam int ApbDataW        = 64;
  localparam int ApbAddrW        = 6;
  localparam int RegIdxW         = 3;

  localparam logic [KwCountW-1:0] KwCountReset = KwCountW'(1);

  // register index codes, byte address is 8 * index
  localparam logic [RegIdxW-1:0] RegText0   = 3'd0;
  localparam logic [RegIdxW-1:0] RegText1   = 3'd1;
  localparam logic [RegIdxW-1:0] RegText2   = 3'd2;
  localparam logic [RegIdxW-1:0] RegText3   = 3'd3;
  localparam logic [RegIdxW-1:0] RegLengths = 3'd4;
  localparam logic [RegIdxW-1:0] RegCount   = 3'd5;

  typedef struct packed {
    logic [NumKeywords-1:0][KwTextW-1:0] text;
    logic [NumKeywords-1:0][KwLenW-1:0]  len;
    logic [NumKeywords-1:0]              active;
  } mklm_kw_cfg_t;

  // clamp a length nibble to the longest keyword the matcher handles (MaxKeywordBytes)
  function automatic logic [KwLenW-1:0] sat_len(input logic [KwLenW-1:0] n);
    logic [KwLenW-1:0] res;
    res = (n > KwLenW'(MaxKeywordBytes)) ? KwLenW'(MaxKeywordBytes) : n;
    return res;
  endfunction

endpackage
`default_nettype wire

FILE: design/mklm_cfg.sv
// mklm_cfg: APB-style register file holding keyword text, lengths and count.
// Depends on mklm_pkg.
`default_nettype none
module mklm_cfg (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [mklm_pkg::ApbAddrW-1:0]  paddr,
  input  wire logic [mklm_pkg::ApbDataW-1:0]  pwdata,
  output logic      [mklm_pkg::ApbDataW-1:0]  prdata,
  output logic                                pready,
  output mklm_pkg::mklm_kw_cfg_t              kw_cfg_o
);
  import mklm_pkg::*;

  logic [NumKeywords-1:0][KwTextW-1:0] text_q;
  logic [NumKeywords-1:0][KwLenW-1:0]  len_q;
  logic [KwCountW-1:0]                 count_q;
  logic                                wr_en;
  logic [RegIdxW-1:0]                  idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[5:3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      text_q  <= '0;
      len_q   <= '0;
      count_q <= KwCountReset;
    end else if (wr_en) begin
      unique case (idx)
        RegText0: text_q[0] <= pwdata;
        RegText1: text_q[1] <= pwdata;
        RegText2: text_q[2] <= pwdata;
        RegText3: text_q[3] <= pwdata;
        RegLengths: begin
          for (int k = 0; k < NumKeywords; k++) begin
            len_q[k] <= sat_len(pwdata[KwLenW*k +: KwLenW]);
          end
        end
        RegCount: count_q <= pwdata[KwCountW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      RegText0:   prdata = text_q[0];
      RegText1:   prdata = text_q[1];
      RegText2:   prdata = text_q[2];
      RegText3:   prdata = text_q[3];
      RegLengths: prdata = ApbDataW'(len_q);
      RegCount:   prdata = ApbDataW'(count_q);
      default:    prdata = '0;
    endcase
  end

  always_comb begin
    kw_cfg_o.text = text_q;
    kw_cfg_o.len  = len_q;
    for (int k = 0; k < NumKeywords; k++) begin
      // a count above the keyword total enables all of them
      kw_cfg_o.active[k] = (count_q > KwCountW'(k));
    end
  end

endmodule
`default_nettype wire

FILE: design/mklm_cell.sv
// mklm_cell: one position of the recent-byte chain, one byte plus a valid bit.
// Depends on mklm_pkg.
`default_nettype none
module mklm_cell (
  input  wire logic                                               clk_i,
  input  wire logic                                               rst_ni,
  input  wire logic                                               adv_i,
  input  wire logic                                               clr_i,
  input  wire logic [mklm_pkg::ByteW-1:0]                         byte_i,
  input  wire logic                                               valid_i,
  input  wire logic [mklm_pkg::NumKeywords-1:0][mklm_pkg::ByteW-1:0] kw_byte_i,
  input  wire logic [mklm_pkg::NumKeywords-1:0]                   need_i,
  output logic      [mklm_pkg::ByteW-1:0]                         byte_o,
  output logic                                                    valid_o,
  output logic      [mklm_pkg::NumKeywords-1:0]                   eq_o
);
  import mklm_pkg::*;

  logic [ByteW-1:0] byte_q;
  logic             valid_q;

  // a position the keyword does not reach always agrees
  always_comb begin
    for (int k = 0; k < NumKeywords; k++) begin
      eq_o[k] = !need_i[k] || (valid_q && (byte_q == kw_byte_i[k]));
    end
  end

  assign byte_o  = byte_q;
  assign valid_o = valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q  <= '0;
      valid_q <= 1'b0;
    end else if (clr_i) begin
      byte_q  <= '0;
      valid_q <= 1'b0;
    end else if (adv_i) begin
      byte_q  <= byte_i;
      valid_q <= valid_i;
    end
  end

endmodule
`default_nettype wire

FILE: design/multi_keyword_line_match.sv
// multi_keyword_line_match: AND search of up to four keywords in each text line.
// Depends on mklm_pkg, mklm_cfg and mklm_cell.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one item per cycle unless
//   stalled: a text byte, or a line end flagged by line_end_i (its byte is the
//   delimiter and is dropped). Output channel (out_valid_o / out_stall_i)
//   carries one item per line end: line_match_o and the keywords_seen_o bitmap.
//   Throughput is one input item per cycle while in_stall_o is low. A line-end
//   item's result is registered in the output register, or else in the skid entry.
//   A row of seven cells holds the last seven bytes of the line, each with a
//   valid bit; each byte shifts the row by one position, and a keyword of length
//   L is found when the current byte and the first L-1 cells equal its bytes.
//   The output register is backed by one skid entry: the input keeps flowing
//   while a result waits, and the input stalls only once the skid entry holds a
//   second result that the receiver has not yet taken.
//   Reset clears the byte row, the found flags, both output entries and the
//   keyword registers (keyword_count comes up as 1). There is no clearing pass.
//   Write the keyword registers over the APB-style port only while idle.
`default_nettype none
module multi_keyword_line_match (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // configuration port
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [mklm_pkg::ApbAddrW-1:0]  paddr,
  input  wire logic [mklm_pkg::ApbDataW-1:0]  pwdata,
  output logic      [mklm_pkg::ApbDataW-1:0]  prdata,
  output logic                                pready,
  // input items
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic [mklm_pkg::ByteW-1:0]     text_byte_i,
  input  wire logic                           line_end_i,
  // result items
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic                                line_match_o,
  output logic [mklm_pkg::NumKeywords-1:0]    keywords_seen_o
);
  import mklm_pkg::*;

  localparam int NumCells = MaxKeywordBytes - 1;
  localparam int SelW     = $clog2(MaxKeywordBytes);

  mklm_kw_cfg_t kw_cfg;

  mklm_cfg u_cfg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .kw_cfg_o (kw_cfg)
  );

  // handshake
  logic accept;
  logic adv;
  logic clr;

  assign accept = in_valid_i && !in_stall_o;
  assign adv    = accept && !line_end_i;
  assign clr    = accept && line_end_i;

  // cell row: cell j holds the line byte j+1 positions back
  logic [ByteW-1:0]                  link_byte[NumCells];
  logic                              link_vld [NumCells];
  logic [ByteW-1:0]                  row_byte [NumCells];
  logic                              row_vld  [NumCells];
  logic [NumKeywords-1:0]            need     [NumCells];
  logic [NumKeywords-1:0]            eq       [NumCells];
  logic [NumKeywords-1:0][SelW-1:0]  kw_sel   [NumCells];
  logic [NumKeywords-1:0][ByteW-1:0] kw_col   [NumCells];

  for (genvar j = 0; j < NumCells; j++) begin : g_cell
    // the first cell takes the current byte, the others their neighbor's
    if (j == 0) begin : g_head
      assign link_byte[j] = text_byte_i;
      assign link_vld[j]  = 1'b1;
    end else begin : g_link
      assign link_byte[j] = row_byte[j-1];
      assign link_vld[j]  = row_vld[j-1];
    end

    // keyword byte L-2-j lines up with this cell when the keyword reaches it
    for (genvar k = 0; k < NumKeywords; k++) begin : g_kw
      assign need[j][k]   = (kw_cfg.len[k] > KwLenW'(j + 1));
      assign kw_sel[j][k] = SelW'(kw_cfg.len[k] - KwLenW'(j + 2));
      assign kw_col[j][k] = kw_cfg.text[k][ByteW*kw_sel[j][k] +: ByteW];
    end

    mklm_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .adv_i     (adv),
      .clr_i     (clr),
      .byte_i    (link_byte[j]),
      .valid_i   (link_vld[j]),
      .kw_byte_i (kw_col[j]),
      .need_i    (need[j]),
      .byte_o    (row_byte[j]),
      .valid_o   (row_vld[j]),
      .eq_o      (eq[j])
    );
  end

  // current byte against the last byte of every keyword
  logic [NumKeywords-1:0][SelW-1:0] cur_sel;
  logic [NumKeywords-1:0]           cur_eq;

  for (genvar k = 0; k < NumKeywords; k++) begin : g_tail
    assign cur_sel[k] = SelW'(kw_cfg.len[k] - KwLenW'(1));
    assign cur_eq[k]  = (kw_cfg.len[k] != '0) &&
                        (text_byte_i == kw_cfg.text[k][ByteW*cur_sel[k] +: ByteW]);
  end

  // found flags: a keyword hits when every position agrees, only for active ones
  logic [NumKeywords-1:0] hit_any;
  logic [NumKeywords-1:0] found_d;
  logic [NumKeywords-1:0] found_q;

  always_comb begin
    hit_any = cur_eq;
    for (int j = 0; j < NumCells; j++) begin
      hit_any = hit_any & eq[j];
    end
    found_d = found_q | (hit_any & kw_cfg.active);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= '0;
    end else if (clr) begin
      found_q <= '0;
    end else if (adv) begin
      found_q <= found_d;
    end
  end

  // line result: an empty keyword counts as found
  logic [NumKeywords-1:0] len_zero;
  logic [NumKeywords-1:0] seen;
  logic                   all_hit;

  always_comb begin
    for (int k = 0; k < NumKeywords; k++) begin
      len_zero[k] = (kw_cfg.len[k] == '0);
    end
    seen    = kw_cfg.active & (len_zero | found_q);
    all_hit = &(~kw_cfg.active | seen);
  end

  // output register plus skid entry
  logic                   out_valid_q;
  logic                   out_match_q;
  logic [NumKeywords-1:0] out_seen_q;
  logic                   skid_valid_q;
  logic                   skid_match_q;
  logic [NumKeywords-1:0] skid_seen_q;
  logic                   take;

  assign take       = out_valid_q && !out_stall_i;
  assign in_stall_o = skid_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      // input is stalled; drain the skid entry once the output moves
      if (take) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end
    end else if (clr) begin
      if (!out_valid_q || take) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (take) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (take) begin
        out_match_q <= skid_match_q;
        out_seen_q  <= skid_seen_q;
      end
    end else if (clr) begin
      if (!out_valid_q || take) begin
        out_match_q <= all_hit;
        out_seen_q  <= seen;
      end else begin
        skid_match_q <= all_hit;
        skid_seen_q  <= seen;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign line_match_o    = out_match_q;
  assign keywords_seen_o = out_seen_q;

endmodule
`default_nettype wire
